FILE: design/wheel_link_poll_framer_defines.svh
// Assertion helpers for the wheel link poll framer.
`ifndef WHEEL_LINK_POLL_FRAMER_DEFINES_SVH
`define WHEEL_LINK_POLL_FRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WLPF_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wheel_link_poll_framer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WLPF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wheel_link_poll_framer: next-cycle check failed");

`endif

FILE: design/wlpf_pkg.sv
package wlpf_pkg;

  typedef enum logic [2:0] {
    CMD_POLL    = 3'd0,
    CMD_SPEED   = 3'd1,
    CMD_HALT    = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_REQUEST = 3'd4,
    CMD_REPLY   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    RR_NONE      = 3'd0,
    RR_OK        = 3'd1,
    RR_BAD_START = 3'd2,
    RR_BAD_ID    = 3'd3,
    RR_BAD_CRC   = 3'd4
  } reply_result_e;

  typedef enum logic [2:0] {
    CFG_POLL_DIVIDER  = 3'd0,
    CFG_SNOOZE_TICKS  = 3'd1,
    CFG_CMD_START     = 3'd2,
    CFG_STATUS_OPCODE = 3'd3,
    CFG_SPEED_OPCODE  = 3'd4,
    CFG_STOP_OPCODE   = 3'd5,
    CFG_REPLY_START   = 3'd6,
    CFG_REPLY_ID      = 3'd7
  } cfg_idx_e;

  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [7:0] RST_POLL_DIVIDER  = 8'd10;
  localparam logic [7:0] RST_SNOOZE_TICKS  = 8'd3;
  localparam logic [7:0] RST_CMD_START     = 8'd170;
  localparam logic [7:0] RST_STATUS_OPCODE = 8'd3;
  localparam logic [7:0] RST_SPEED_OPCODE  = 8'd1;
  localparam logic [7:0] RST_STOP_OPCODE   = 8'd2;
  localparam logic [7:0] RST_REPLY_START   = 8'd171;
  localparam logic [7:0] RST_REPLY_ID      = 8'd16;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] target_speed;
    logic [31:0]        requester;
    logic [63:0]        reply_frame;
  } in_word_t;

  typedef struct packed {
    logic               frame_valid;
    logic [39:0]        tx_frame;
    logic [2:0]         reply_result;
    logic signed [15:0] wheel_speed;
    logic signed [15:0] wheel_torque;
    logic [7:0]         running_flag;
    logic               deliver;
    logic [31:0]        deliver_to;
  } out_word_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [39:0] make_frame(input logic [7:0] start, input logic [7:0] opcode,
                                             input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] c;
    c = crc8_byte(8'h00, start);
    c = crc8_byte(c, opcode);
    c = crc8_byte(c, hi);
    c = crc8_byte(c, lo);
    return {start, opcode, hi, lo, c};
  endfunction

  function automatic logic [7:0] crc8_reply(input logic [55:0] bytes);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 7; i++) begin
      c = crc8_byte(c, bytes[55 - 8 * i -: 8]);
    end
    return c;
  endfunction

endpackage

FILE: design/wheel_link_poll_framer.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------
// in       | in_valid_i / in_stall_o    | in_word_i  (in_word_t)
// out      | out_valid_o / out_stall_i  | out_word_o (out_word_t)
// cfg      | cfg_we_i, cfg_idx_i        | cfg_wdata_i (8 bits)
//
// One word per cycle unless stalled; each result is registered in out_q or skid_q.
// Frame CRC and reply CRC are unrolled XOR logic between input and result register.
// Reset clears counters, the pending request and the output/skid valid flags.
// A one-entry skid stage keeps the input open for one word while the output stalls;
// in_stall_o rises only when both output register and skid stage hold words.
`include "wheel_link_poll_framer_defines.svh"

module wheel_link_poll_framer
  import wlpf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  logic [7:0]  poll_divider_q, snooze_ticks_q, cmd_start_q, status_op_q;
  logic [7:0]  speed_op_q, stop_op_q, reply_start_q, reply_id_q;

  logic        status_pending_q, status_pending_d;
  logic [31:0] pending_req_q, pending_req_d;
  logic [7:0]  snooze_left_q, snooze_left_d;
  logic [7:0]  poll_count_q, poll_count_d;

  logic        out_valid_q, skid_valid_q;
  out_word_t   out_q, skid_q, res;

  logic        in_acc, out_take, main_free;
  logic [8:0]  poll_next;
  logic [39:0] status_frame;
  logic [7:0]  reply_crc;

  assign in_acc       = in_valid_i && !skid_valid_q;
  assign out_take     = out_valid_q && !out_stall_i;
  assign main_free    = !out_valid_q || out_take;
  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_word_o   = out_q;
  assign poll_next    = {1'b0, poll_count_q} + 9'd1;
  assign status_frame = make_frame(cmd_start_q, status_op_q, 8'h00, 8'h00);
  assign reply_crc    = crc8_reply(in_word_i.reply_frame[63:8]);

  always_comb begin
    res              = '0;
    status_pending_d = status_pending_q;
    pending_req_d    = pending_req_q;
    snooze_left_d    = snooze_left_q;
    poll_count_d     = poll_count_q;
    unique case (in_word_i.cmd)
      CMD_POLL: begin
        priority if (status_pending_q) begin
          res.frame_valid = 1'b1;
          res.tx_frame    = status_frame;
        end else if (snooze_left_q != 8'd0) begin
          snooze_left_d = snooze_left_q - 8'd1;
        end else if (poll_next >= {1'b0, poll_divider_q}) begin
          poll_count_d    = 8'd0;
          res.frame_valid = 1'b1;
          res.tx_frame    = status_frame;
        end else begin
          poll_count_d = poll_next[7:0];
        end
      end
      CMD_SPEED: begin
        res.frame_valid = 1'b1;
        res.tx_frame    = make_frame(cmd_start_q, speed_op_q, in_word_i.target_speed[15:8],
                                     in_word_i.target_speed[7:0]);
        snooze_left_d   = snooze_ticks_q;
      end
      CMD_HALT: begin
        res.frame_valid = 1'b1;
        res.tx_frame    = make_frame(cmd_start_q, stop_op_q, 8'h00, 8'h00);
        snooze_left_d   = snooze_ticks_q;
      end
      CMD_QUERY: begin
        res.frame_valid = 1'b1;
        res.tx_frame    = status_frame;
        snooze_left_d   = snooze_ticks_q;
      end
      CMD_REQUEST: begin
        status_pending_d = 1'b1;
        pending_req_d    = in_word_i.requester;
        snooze_left_d    = snooze_ticks_q;
      end
      CMD_REPLY: begin
        priority if (in_word_i.reply_frame[63:56] != reply_start_q) begin
          res.reply_result = RR_BAD_START;
        end else if (in_word_i.reply_frame[55:48] != reply_id_q) begin
          res.reply_result = RR_BAD_ID;
        end else if (reply_crc != in_word_i.reply_frame[7:0]) begin
          res.reply_result = RR_BAD_CRC;
        end else begin
          res.reply_result = RR_OK;
          res.wheel_speed  = in_word_i.reply_frame[47:32];
          res.wheel_torque = in_word_i.reply_frame[31:16];
          res.running_flag = in_word_i.reply_frame[15:8];
          if (status_pending_q) begin
            if (pending_req_q != 32'd0) begin
              res.deliver    = 1'b1;
              res.deliver_to = pending_req_q;
            end
            status_pending_d = 1'b0;
            pending_req_d    = 32'd0;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_divider_q   <= RST_POLL_DIVIDER;
      snooze_ticks_q   <= RST_SNOOZE_TICKS;
      cmd_start_q      <= RST_CMD_START;
      status_op_q      <= RST_STATUS_OPCODE;
      speed_op_q       <= RST_SPEED_OPCODE;
      stop_op_q        <= RST_STOP_OPCODE;
      reply_start_q    <= RST_REPLY_START;
      reply_id_q       <= RST_REPLY_ID;
      status_pending_q <= 1'b0;
      pending_req_q    <= 32'd0;
      snooze_left_q    <= 8'd0;
      poll_count_q     <= 8'd0;
      out_valid_q      <= 1'b0;
      skid_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POLL_DIVIDER:  poll_divider_q <= cfg_wdata_i;
          CFG_SNOOZE_TICKS:  snooze_ticks_q <= cfg_wdata_i;
          CFG_CMD_START:     cmd_start_q    <= cfg_wdata_i;
          CFG_STATUS_OPCODE: status_op_q    <= cfg_wdata_i;
          CFG_SPEED_OPCODE:  speed_op_q     <= cfg_wdata_i;
          CFG_STOP_OPCODE:   stop_op_q      <= cfg_wdata_i;
          CFG_REPLY_START:   reply_start_q  <= cfg_wdata_i;
          CFG_REPLY_ID:      reply_id_q     <= cfg_wdata_i;
          default:           reply_id_q     <= reply_id_q;
        endcase
      end
      if (in_acc) begin
        status_pending_q <= status_pending_d;
        pending_req_q    <= pending_req_d;
        snooze_left_q    <= snooze_left_d;
        poll_count_q     <= poll_count_d;
      end
      if (main_free) begin
        out_valid_q  <= skid_valid_q || in_acc;
        skid_valid_q <= 1'b0;
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  `WLPF_ASSERT_NOW(a_skid_behind_main, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `WLPF_ASSERT_NEXT(a_stalled_word_to_skid, clk_i, rst_ni,
                    in_acc && out_valid_q && out_stall_i, skid_valid_q)
  `WLPF_ASSERT_NOW(a_deliver_needs_ok, clk_i, rst_ni,
                   out_valid_q && out_q.deliver, out_q.reply_result == RR_OK)
  `WLPF_ASSERT_NOW(a_idle_request_clear, clk_i, rst_ni, !status_pending_q, pending_req_q == 32'd0)
  `WLPF_ASSERT_NOW(a_empty_frame_zero, clk_i, rst_ni,
                   out_valid_q && !out_q.frame_valid, out_q.tx_frame == 40'd0)

endmodule

FILE: test/wlpf_link_check.sv
module wlpf_link_check
  import wlpf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  output int        fail_count_o,
  output int        open_count_o,
  output int        checked_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  out_word_t   frames_due[$];
  out_word_t   due_word;
  logic [7:0]  reg_q [8];
  logic        status_pending = 1'b0;
  logic [31:0] pending_requester = '0;
  logic [7:0]  snooze_left = '0;
  logic [7:0]  poll_count = '0;
  int          fails = 0;
  int          checked = 0;

  assign fail_count_o    = fails;
  assign open_count_o    = frames_due.size();
  assign checked_count_o = checked;

  function automatic logic [7:0] crc8(input logic [55:0] msg, input int nbytes);
    logic [7:0] c;
    c = 8'h00;
    for (int i = nbytes - 1; i >= 0; i--) begin
      c = c ^ msg[8*i +: 8];
      for (int k = 0; k < 8; k++) begin
        c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [39:0] frame_of(input logic [7:0] opcode, input logic [7:0] hi,
                                           input logic [7:0] lo);
    logic [31:0] head;
    head = {reg_q[CFG_CMD_START], opcode, hi, lo};
    return {head, crc8({24'h0, head}, 4)};
  endfunction

  function automatic out_word_t frame_for_word(input in_word_t w);
    out_word_t r;
    r = '0;
    case (w.cmd)
      CMD_POLL: begin
        if (status_pending) begin
          r.frame_valid = 1'b1;
          r.tx_frame    = frame_of(reg_q[CFG_STATUS_OPCODE], 8'h00, 8'h00);
        end else if (snooze_left != 8'd0) begin
          snooze_left = snooze_left - 8'd1;
        end else if ({1'b0, poll_count} + 9'd1 >= {1'b0, reg_q[CFG_POLL_DIVIDER]}) begin
          poll_count    = 8'd0;
          r.frame_valid = 1'b1;
          r.tx_frame    = frame_of(reg_q[CFG_STATUS_OPCODE], 8'h00, 8'h00);
        end else begin
          poll_count = poll_count + 8'd1;
        end
      end
      CMD_SPEED: begin
        r.frame_valid = 1'b1;
        r.tx_frame    = frame_of(reg_q[CFG_SPEED_OPCODE], w.target_speed[15:8],
                                 w.target_speed[7:0]);
        snooze_left   = reg_q[CFG_SNOOZE_TICKS];
      end
      CMD_HALT: begin
        r.frame_valid = 1'b1;
        r.tx_frame    = frame_of(reg_q[CFG_STOP_OPCODE], 8'h00, 8'h00);
        snooze_left   = reg_q[CFG_SNOOZE_TICKS];
      end
      CMD_QUERY: begin
        r.frame_valid = 1'b1;
        r.tx_frame    = frame_of(reg_q[CFG_STATUS_OPCODE], 8'h00, 8'h00);
        snooze_left   = reg_q[CFG_SNOOZE_TICKS];
      end
      CMD_REQUEST: begin
        status_pending    = 1'b1;
        pending_requester = w.requester;
        snooze_left       = reg_q[CFG_SNOOZE_TICKS];
      end
      CMD_REPLY: begin
        if (w.reply_frame[63:56] != reg_q[CFG_REPLY_START]) begin
          r.reply_result = RR_BAD_START;
        end else if (w.reply_frame[55:48] != reg_q[CFG_REPLY_ID]) begin
          r.reply_result = RR_BAD_ID;
        end else if (crc8(w.reply_frame[63:8], 7) != w.reply_frame[7:0]) begin
          r.reply_result = RR_BAD_CRC;
        end else begin
          r.reply_result = RR_OK;
          r.wheel_speed  = w.reply_frame[47:32];
          r.wheel_torque = w.reply_frame[31:16];
          r.running_flag = w.reply_frame[15:8];
          if (status_pending) begin
            if (pending_requester != 32'd0) begin
              r.deliver    = 1'b1;
              r.deliver_to = pending_requester;
            end
            status_pending    = 1'b0;
            pending_requester = 32'd0;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report(input string msg);
    fails++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q[CFG_POLL_DIVIDER]  = RST_POLL_DIVIDER;
      reg_q[CFG_SNOOZE_TICKS]  = RST_SNOOZE_TICKS;
      reg_q[CFG_CMD_START]     = RST_CMD_START;
      reg_q[CFG_STATUS_OPCODE] = RST_STATUS_OPCODE;
      reg_q[CFG_SPEED_OPCODE]  = RST_SPEED_OPCODE;
      reg_q[CFG_STOP_OPCODE]   = RST_STOP_OPCODE;
      reg_q[CFG_REPLY_START]   = RST_REPLY_START;
      reg_q[CFG_REPLY_ID]      = RST_REPLY_ID;
      status_pending    = 1'b0;
      pending_requester = '0;
      snooze_left       = '0;
      poll_count        = '0;
      frames_due.delete();
    end else begin
      if (cfg_we_i) begin
        reg_q[cfg_idx_i] = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        frames_due.push_back(frame_for_word(in_word_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          report("result word with no expectation waiting");
        end else begin
          due_word = frames_due.pop_front();
          checked++;
          check_field("frame_valid", 64'(out_word_i.frame_valid), 64'(due_word.frame_valid));
          check_field("tx_frame", 64'(out_word_i.tx_frame), 64'(due_word.tx_frame));
          check_field("reply_result", 64'(out_word_i.reply_result),
                      64'(due_word.reply_result));
          check_field("wheel_speed", 64'(out_word_i.wheel_speed), 64'(due_word.wheel_speed));
          check_field("wheel_torque", 64'(out_word_i.wheel_torque),
                      64'(due_word.wheel_torque));
          check_field("running_flag", 64'(out_word_i.running_flag),
                      64'(due_word.running_flag));
          check_field("deliver", 64'(out_word_i.deliver), 64'(due_word.deliver));
          check_field("deliver_to", 64'(out_word_i.deliver_to), 64'(due_word.deliver_to));
        end
      end
    end
  end

endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wlpf_pkg::*;

  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;
  localparam int         NUM_PHASES   = 10;

  typedef enum {RX_GOOD, RX_BAD_START, RX_BAD_ID, RX_BAD_CRC, RX_NOISE} rx_kind_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_word_t   in_word_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_word_t  out_word_o;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_idx_i   = CFG_POLL_DIVIDER;
  logic [7:0] cfg_wdata_i = '0;

  int         fail_count;
  int         open_count;
  int         checked_count;
  int         idle_pct    = 0;
  int         stall_left  = 0;
  int         words_sent  = 0;
  logic [7:0] cur_cfg [8];

  always #10 clk_i = ~clk_i;

  wheel_link_poll_framer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  wlpf_link_check link_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_word_i       (in_word_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word_i      (out_word_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_count_o    (fail_count),
    .open_count_o    (open_count),
    .checked_count_o (checked_count)
  );

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (rst_ni && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [63:0] make_reply(input rx_kind_e kind, input logic [39:0] body);
    logic [55:0] head;
    logic [7:0]  crc;
    head = {cur_cfg[CFG_REPLY_START], cur_cfg[CFG_REPLY_ID], body};
    crc  = crc8_reply(head);
    case (kind)
      RX_BAD_START: head[55:48] = head[55:48] ^ 8'($urandom_range(1, 255));
      RX_BAD_ID:    head[47:40] = head[47:40] ^ 8'($urandom_range(1, 255));
      RX_BAD_CRC:   crc = crc ^ 8'($urandom_range(1, 255));
      RX_NOISE:     return {$urandom, $urandom};
      default: begin
      end
    endcase
    return {head, crc};
  endfunction

  task automatic load_defaults();
    cur_cfg[CFG_POLL_DIVIDER]  = RST_POLL_DIVIDER;
    cur_cfg[CFG_SNOOZE_TICKS]  = RST_SNOOZE_TICKS;
    cur_cfg[CFG_CMD_START]     = RST_CMD_START;
    cur_cfg[CFG_STATUS_OPCODE] = RST_STATUS_OPCODE;
    cur_cfg[CFG_SPEED_OPCODE]  = RST_SPEED_OPCODE;
    cur_cfg[CFG_STOP_OPCODE]   = RST_STOP_OPCODE;
    cur_cfg[CFG_REPLY_START]   = RST_REPLY_START;
    cur_cfg[CFG_REPLY_ID]      = RST_REPLY_ID;
  endtask

  task automatic send(input logic [2:0] cmd, input logic [15:0] spd, input logic [31:0] req,
                      input logic [63:0] rx);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{cmd, spd, req, rx};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic random_item();
    int          pick;
    int          kind_pick;
    logic [31:0] req;
    rx_kind_e    kind;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send(CMD_POLL, 16'($urandom), $urandom, {$urandom, $urandom});
    end else if (pick < 50) begin
      send(CMD_SPEED, 16'($urandom), $urandom, {$urandom, $urandom});
    end else if (pick < 55) begin
      send(CMD_HALT, 16'($urandom), $urandom, {$urandom, $urandom});
    end else if (pick < 60) begin
      send(CMD_QUERY, 16'($urandom), $urandom, {$urandom, $urandom});
    end else if (pick < 70) begin
      req = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      send(CMD_REQUEST, 16'($urandom), req, {$urandom, $urandom});
    end else if (pick < 97) begin
      kind_pick = $urandom_range(0, 99);
      kind = (kind_pick < 70) ? RX_GOOD :
             (kind_pick < 78) ? RX_BAD_START :
             (kind_pick < 86) ? RX_BAD_ID :
             (kind_pick < 94) ? RX_BAD_CRC : RX_NOISE;
      send(CMD_REPLY, 16'($urandom), $urandom, make_reply(kind, {$urandom, 8'($urandom)}));
    end else begin
      send($urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B, 16'($urandom), $urandom,
           {$urandom, $urandom});
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs();
    cfg_idx_e idx;
    idx = idx.first();
    do begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= cur_cfg[idx];
      @(posedge clk_i);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    load_defaults();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 20;

    send(CMD_POLL, '0, '0, '0);
    send(CMD_SPEED, 16'h7FFF, '0, '0);
    send(CMD_SPEED, 16'h8000, '0, '0);
    send(CMD_SPEED, 16'hFFFF, '0, '0);
    send(CMD_HALT, '0, '0, '0);
    send(CMD_QUERY, '0, '0, '0);
    repeat (4) send(CMD_POLL, '0, '0, '0);
    send(CMD_REQUEST, '0, 32'hFFFF_FFFF, '0);
    send(CMD_POLL, '0, '0, '0);
    send(CMD_REPLY, '0, '0, make_reply(RX_BAD_CRC, {16'h8000, 16'h7FFF, 8'hFF}));
    send(CMD_REPLY, '0, '0, make_reply(RX_GOOD, {16'h8000, 16'h7FFF, 8'hFF}));
    send(CMD_REPLY, '0, '0, make_reply(RX_GOOD, {16'h7FFF, 16'h8000, 8'h00}));
    send(CMD_REPLY, '0, '0, make_reply(RX_BAD_START, {$urandom, 8'($urandom)}));
    send(CMD_REPLY, '0, '0, make_reply(RX_BAD_ID, {$urandom, 8'($urandom)}));
    send(CMD_REQUEST, '0, '0, '0);
    send(CMD_POLL, '0, '0, '0);
    send(CMD_REPLY, '0, '0, make_reply(RX_GOOD, {$urandom, 8'($urandom)}));
    send(CMD_UNUSED_A, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(CMD_UNUSED_B, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    repeat (8) send(CMD_POLL, '0, '0, '0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      foreach (cur_cfg[i]) cur_cfg[i] = 8'($urandom);
      cur_cfg[CFG_POLL_DIVIDER] = 8'($urandom_range(1, 12));
      cur_cfg[CFG_SNOOZE_TICKS] = 8'($urandom_range(0, 5));
      idle_pct = (phase % 3 == 1) ? 0 : 30;
      case (phase)
        0: begin
          cur_cfg[CFG_POLL_DIVIDER] = 8'd1;
          cur_cfg[CFG_SNOOZE_TICKS] = 8'd0;
        end
        1: begin
          cur_cfg[CFG_POLL_DIVIDER] = 8'd255;
          cur_cfg[CFG_SNOOZE_TICKS] = 8'd0;
        end
        2: begin
          cur_cfg[CFG_POLL_DIVIDER] = 8'd0;
          cur_cfg[CFG_SNOOZE_TICKS] = 8'd255;
        end
        3: begin
          foreach (cur_cfg[i]) cur_cfg[i] = 8'h00;
          cur_cfg[CFG_POLL_DIVIDER] = 8'd2;
          cur_cfg[CFG_SNOOZE_TICKS] = 8'd1;
        end
        4: begin
          foreach (cur_cfg[i]) cur_cfg[i] = 8'hFF;
          cur_cfg[CFG_POLL_DIVIDER] = 8'd3;
          cur_cfg[CFG_SNOOZE_TICKS] = 8'd2;
        end
        NUM_PHASES - 1: begin
          load_defaults();
          idle_pct = 0;
        end
        default: begin
        end
      endcase
      program_regs();
      if (phase == 1) begin
        repeat (260) send(CMD_POLL, 16'($urandom), $urandom, {$urandom, $urandom});
      end
      repeat (85) random_item();
    end

    settle();
    $display("Drove %0d words across %0d register settings, divider and snooze extremes included.",
             words_sent, NUM_PHASES + 1);
    $display("Compared %0d result words, %0d field mismatches.", checked_count, fail_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
